/* rtl/core/cpek_pkg.sv */
package cpek_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_VENDOR   = 3'd0;
  localparam logic [2:0] REG_DEVTYPE  = 3'd1;
  localparam logic [2:0] REG_PRODCODE = 3'd2;
  localparam logic [2:0] REG_MAJOR_REV = 3'd3;
  localparam logic [2:0] REG_MINOR_REV = 3'd4;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Segment header decode
  localparam logic [7:0] SEG_TYPE_MASK     = 8'hE0;
  localparam logic [7:0] SEG_LOGICAL       = 8'h20;
  localparam logic [7:0] LOG_TYPE_MASK     = 8'h1C;
  localparam logic [7:0] LOG_TYPE_SPECIAL  = 8'h14;
  localparam logic [7:0] LOG_TYPE_EXTENDED = 8'h1C;
  localparam logic [1:0] FMT_8BIT          = 2'd0;
  localparam logic [1:0] FMT_16BIT         = 2'd1;
  localparam logic [1:0] FMT_32BIT         = 2'd2;
  localparam logic [1:0] FMT_RESERVED      = 2'd3;

  // Segment sizes in bytes
  localparam logic [3:0] LEN_KEY      = 4'd10;
  localparam logic [3:0] LEN_EXT_8BIT = 4'd3;
  localparam logic [3:0] LEN_8BIT     = 4'd2;
  localparam logic [3:0] LEN_16BIT    = 4'd4;
  localparam logic [3:0] LEN_32BIT    = 4'd6;

  // Byte positions inside an electronic key segment
  localparam logic [3:0] KEY_OFS_FORMAT  = 4'd1;
  localparam logic [3:0] KEY_OFS_VEND_LO = 4'd2;
  localparam logic [3:0] KEY_OFS_VEND_HI = 4'd3;
  localparam logic [3:0] KEY_OFS_DEV_LO  = 4'd4;
  localparam logic [3:0] KEY_OFS_DEV_HI  = 4'd5;
  localparam logic [3:0] KEY_OFS_PROD_LO = 4'd6;
  localparam logic [3:0] KEY_OFS_PROD_HI = 4'd7;
  localparam logic [3:0] KEY_OFS_MAJOR   = 4'd8;

  localparam logic [7:0] KEY_FORMAT_FOUR = 8'h04;

  localparam logic VERDICT_OK    = 1'b0;
  localparam logic VERDICT_ERROR = 1'b1;

  // Device identity that keys are compared with
  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] devtype;
    logic [15:0] prodcode;
    logic [6:0]  major_rev;
    logic [7:0]  minor_rev;
  } cpek_cfg_t;

endpackage

/* rtl/core/cpek_cfg_regs.sv */
module cpek_cfg_regs
  import cpek_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cpek_cfg_t         cfg_o
);

  cpek_cfg_t   cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_VENDOR:    cfg_q.vendor    <= pwdata[15:0];
        REG_DEVTYPE:   cfg_q.devtype   <= pwdata[15:0];
        REG_PRODCODE:  cfg_q.prodcode  <= pwdata[15:0];
        REG_MAJOR_REV: cfg_q.major_rev <= pwdata[6:0];
        REG_MINOR_REV: cfg_q.minor_rev <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux, unused addresses read zero
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_VENDOR:    prdata[15:0] = cfg_q.vendor;
      REG_DEVTYPE:   prdata[15:0] = cfg_q.devtype;
      REG_PRODCODE:  prdata[15:0] = cfg_q.prodcode;
      REG_MAJOR_REV: prdata[6:0]  = cfg_q.major_rev;
      REG_MINOR_REV: prdata[7:0]  = cfg_q.minor_rev;
      default:       prdata       = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/cpek_walker.sv */
module cpek_walker
  import cpek_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpek_cfg_t cfg_i,
  input  logic      step_i,
  input  logic [7:0] byte_i,
  input  logic      last_i,
  output logic      verdict_o
);

  logic [3:0] off_q, off_d;
  logic [3:0] len_q, len_d;
  logic       inkey_q, inkey_d;
  logic       dec_q, dec_d;
  logic       held_q, held_d;
  logic [7:0] low_q, low_d;
  logic       mis_q, mis_d;
  logic [7:0] maj_q, maj_d;

  logic [7:0]  seg_type;
  logic [1:0]  fmt;
  logic [15:0] word;
  logic [6:0]  key_major;

  assign seg_type  = byte_i & LOG_TYPE_MASK;
  assign fmt       = byte_i[1:0];
  assign word      = {byte_i, low_q};
  assign key_major = maj_q[6:0];

  // Per-byte segment walk
  always_comb begin
    off_d     = off_q;
    len_d     = len_q;
    inkey_d   = inkey_q;
    dec_d     = dec_q;
    held_d    = held_q;
    low_d     = low_q;
    mis_d     = mis_q;
    maj_d     = maj_q;
    verdict_o = VERDICT_OK;

    if (!dec_q) begin
      if (off_q == 4'd0) begin
        // segment header
        if ((byte_i & SEG_TYPE_MASK) != SEG_LOGICAL) begin
          dec_d  = 1'b1;
          held_d = VERDICT_OK;
        end else if (seg_type == LOG_TYPE_SPECIAL) begin
          if (fmt != FMT_8BIT) begin
            dec_d  = 1'b1;
            held_d = VERDICT_ERROR;
          end else begin
            inkey_d = 1'b1;
            mis_d   = 1'b0;
            len_d   = LEN_KEY;
            off_d   = 4'd1;
          end
        end else begin
          case (fmt)
            FMT_8BIT: begin
              len_d = (seg_type == LOG_TYPE_EXTENDED) ? LEN_EXT_8BIT : LEN_8BIT;
              off_d = 4'd1;
            end
            FMT_16BIT: begin
              len_d = LEN_16BIT;
              off_d = 4'd1;
            end
            FMT_32BIT: begin
              len_d = LEN_32BIT;
              off_d = 4'd1;
            end
            default: begin
              dec_d  = 1'b1;
              held_d = VERDICT_ERROR;
            end
          endcase
        end
      end else begin
        // segment body, key fields checked as they pass
        if (inkey_q) begin
          case (off_q)
            KEY_OFS_FORMAT:  if (byte_i != KEY_FORMAT_FOUR) mis_d = 1'b1;
            KEY_OFS_VEND_LO,
            KEY_OFS_DEV_LO,
            KEY_OFS_PROD_LO: low_d = byte_i;
            KEY_OFS_VEND_HI:
              if (word != 16'd0 && word != cfg_i.vendor) mis_d = 1'b1;
            KEY_OFS_DEV_HI:
              if (word != 16'd0 && word != cfg_i.devtype) mis_d = 1'b1;
            KEY_OFS_PROD_HI:
              if (word != 16'd0 && word != cfg_i.prodcode) mis_d = 1'b1;
            KEY_OFS_MAJOR:   maj_d = byte_i;
            default: begin
              // minor revision byte
              if (!maj_q[7]) begin
                if (key_major != 7'd0 && key_major != cfg_i.major_rev) mis_d = 1'b1;
                if (byte_i != 8'd0 && byte_i != cfg_i.minor_rev) mis_d = 1'b1;
              end else if (key_major != cfg_i.major_rev || byte_i == 8'd0 ||
                           byte_i > cfg_i.minor_rev) begin
                mis_d = 1'b1;
              end
            end
          endcase
        end
        off_d = off_q + 4'd1;
      end

      // segment complete
      if (!dec_d && off_d != 4'd0 && off_d >= len_d) begin
        if (inkey_d && mis_d) begin
          dec_d  = 1'b1;
          held_d = VERDICT_ERROR;
        end
        off_d   = 4'd0;
        len_d   = 4'd0;
        inkey_d = 1'b0;
      end
    end

    // path end: verdict out and clear for the next path
    if (last_i) begin
      verdict_o = dec_d ? held_d : (off_d != 4'd0);
      off_d   = 4'd0;
      len_d   = 4'd0;
      inkey_d = 1'b0;
      dec_d   = 1'b0;
      held_d  = VERDICT_OK;
      low_d   = 8'd0;
      mis_d   = 1'b0;
      maj_d   = 8'd0;
    end
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      len_q   <= '0;
      inkey_q <= 1'b0;
      dec_q   <= 1'b0;
      held_q  <= VERDICT_OK;
      low_q   <= '0;
      mis_q   <= 1'b0;
      maj_q   <= '0;
    end else if (step_i) begin
      off_q   <= off_d;
      len_q   <= len_d;
      inkey_q <= inkey_d;
      dec_q   <= dec_d;
      held_q  <= held_d;
      low_q   <= low_d;
      mis_q   <= mis_d;
      maj_q   <= maj_d;
    end
  end

endmodule

/* rtl/core/cip_path_electronic_key_check_core.sv */
// Path byte checker for CIP electronic keys (format 4).
// Throughput: one path byte per cycle; only a last byte waits, and only while
// an earlier verdict is still stalled in the result register.
// The last byte of a path passes the input register and the walk logic, and its
// verdict is held in the result register until it is taken.
// Reset (rst_ni low, asynchronous) clears walk state, the valid flags of both registers and identity.
module cip_path_electronic_key_check_core
  import cpek_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // path bytes
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] path_byte
  input  logic              s_axis_tlast,
  // verdicts
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [0] verdict, [7:1] zero
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cpek_cfg_t  cfg;
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q, out_valid_d;
  logic       verdict_q, verdict_d;
  logic       out_free;
  logic       advance;
  logic       in_load;
  logic       walk_verdict;

  cpek_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: a non-last word moves on freely, a last word needs the result slot
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  cpek_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .verdict_o (walk_verdict)
  );

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_load) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
      verdict_d   = walk_verdict;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, verdict_q};

endmodule

/* rtl/core/cpek_checker.sv */
module cpek_checker
  import cpek_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [7:0]        m_axis_tdata,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  // A stalled verdict word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict word changed while stalled");

  // Only the verdict bit may be set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("verdict padding not zero");

  // Config port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

  // Vendor id reads back what was written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_VENDOR
    |=> paddr[ADDR_W-1:2] != REG_VENDOR ||
        (prdata[15:0] == $past(pwdata[15:0]) && prdata[DATA_W-1:16] == '0))
    else $error("vendor id readback mismatch");

endmodule

bind cip_path_electronic_key_check_core cpek_checker u_checker (.*);

/* tb/tb.sv */
module tb;
  import cpek_pkg::*;

  localparam int unsigned RANDOM_BYTES   = 1250;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned SETTLE_CYCLES  = 4;    // idle wait after the last expected verdict
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned QUIET_LIMIT    = 4000;

  // Directed paths as {last, byte}
  localparam logic [8:0] DIRECTED_BYTES [23] = '{
    {1'b1, 8'h00},                                   // zero byte as the whole path
    {1'b1, 8'hFF},                                   // non-logical segment, all ones
    {1'b1, 8'h23},                                   // reserved format
    {1'b1, 8'h20},                                   // 8-bit member cut on its header
    {1'b1, 8'h2E},                                   // 32-bit member cut on its header
    {1'b0, 8'h35}, {1'b1, 8'h00},                    // special with nonzero format
    {1'b0, 8'h3C}, {1'b0, 8'h01}, {1'b1, 8'h02},     // extended 8-bit, ends on boundary
    {1'b0, 8'h24}, {1'b0, 8'h07}, {1'b1, 8'h00},     // odd length, zero pad at the end
    // compatibility key: vendor wildcard, device and product exact, minor below own
    {1'b0, 8'h34}, {1'b0, 8'h04}, {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b0, 8'h0C},
    {1'b0, 8'h00}, {1'b0, 8'h5F}, {1'b0, 8'h0A}, {1'b0, 8'h85}, {1'b1, 8'h10}
  };

  // Expected verdicts per path, from a byte-level walk of the segments
  class verdict_scoreboard;
    logic [15:0] own_vendor  = '0;
    logic [15:0] own_device  = '0;
    logic [15:0] own_product = '0;
    logic [6:0]  own_major   = '0;
    logic [7:0]  own_minor   = '0;

    logic [3:0]  seg_pos    = '0;
    logic [3:0]  seg_size   = '0;
    bit          in_key     = 1'b0;
    bit          decided    = 1'b0;
    logic        held       = VERDICT_OK;
    logic [7:0]  word_low   = '0;
    logic [7:0]  major_byte = '0;
    bit          key_bad    = 1'b0;

    logic        expected_verdicts[$];
    int unsigned errors = 0;

    function void set_register(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_VENDOR:    own_vendor  = val[15:0];
        REG_DEVTYPE:   own_device  = val[15:0];
        REG_PRODCODE:  own_product = val[15:0];
        REG_MAJOR_REV: own_major   = val[6:0];
        REG_MINOR_REV: own_minor   = val[7:0];
        default: ;
      endcase
    endfunction

    // nonzero key field that differs from the device identity
    function bit field_bad(logic [7:0] hi, logic [15:0] own);
      logic [15:0] w;
      w = {hi, word_low};
      return (w != 16'd0) && (w != own);
    endfunction

    function void note_path_byte(logic [7:0] b, logic lst);
      logic [1:0] fmt;
      fmt = b[1:0];
      if (!decided) begin
        if (seg_pos == 4'd0) begin
          // segment header
          if ((b & SEG_TYPE_MASK) != SEG_LOGICAL) begin
            decided = 1'b1;
            held = VERDICT_OK;
          end else if ((b & LOG_TYPE_MASK) == LOG_TYPE_SPECIAL) begin
            if (fmt != FMT_8BIT) begin
              decided = 1'b1;
              held = VERDICT_ERROR;
            end else begin
              in_key = 1'b1;
              key_bad = 1'b0;
              seg_size = LEN_KEY;
              seg_pos = 4'd1;
            end
          end else begin
            case (fmt)
              FMT_RESERVED: begin
                decided = 1'b1;
                held = VERDICT_ERROR;
              end
              FMT_8BIT: seg_size = ((b & LOG_TYPE_MASK) == LOG_TYPE_EXTENDED) ?
                                   LEN_EXT_8BIT : LEN_8BIT;
              FMT_16BIT: seg_size = LEN_16BIT;
              default: seg_size = LEN_32BIT;
            endcase
            if (!decided) seg_pos = 4'd1;
          end
        end else begin
          // segment body; only key bytes are looked at
          if (in_key) begin
            case (seg_pos)
              KEY_OFS_FORMAT: if (b != KEY_FORMAT_FOUR) key_bad = 1'b1;
              KEY_OFS_VEND_LO, KEY_OFS_DEV_LO, KEY_OFS_PROD_LO: word_low = b;
              KEY_OFS_VEND_HI: if (field_bad(b, own_vendor)) key_bad = 1'b1;
              KEY_OFS_DEV_HI:  if (field_bad(b, own_device)) key_bad = 1'b1;
              KEY_OFS_PROD_HI: if (field_bad(b, own_product)) key_bad = 1'b1;
              KEY_OFS_MAJOR:   major_byte = b;
              default: begin
                // minor revision byte closes the key
                if (!major_byte[7]) begin
                  if (major_byte[6:0] != 7'd0 && major_byte[6:0] != own_major)
                    key_bad = 1'b1;
                  if (b != 8'd0 && b != own_minor) key_bad = 1'b1;
                end else if (major_byte[6:0] != own_major || b == 8'd0 || b > own_minor) begin
                  key_bad = 1'b1;
                end
              end
            endcase
          end
          seg_pos = seg_pos + 4'd1;
        end
        // segment complete
        if (!decided && seg_pos != 4'd0 && seg_pos >= seg_size) begin
          if (in_key && key_bad) begin
            decided = 1'b1;
            held = VERDICT_ERROR;
          end
          seg_pos = '0;
          seg_size = '0;
          in_key = 1'b0;
        end
      end
      if (lst) begin
        if (!decided) held = (seg_pos == 4'd0) ? VERDICT_OK : VERDICT_ERROR;
        expected_verdicts.push_back(held);
        seg_pos = '0;
        seg_size = '0;
        in_key = 1'b0;
        decided = 1'b0;
        held = VERDICT_OK;
        word_low = '0;
        key_bad = 1'b0;
        major_byte = '0;
      end
    endfunction

    function void flag(string what, logic exp_v, logic [7:0] got);
      errors++;
      if (errors <= 10)
        $display("verdict %s: expected %0b, got %0b (tdata %h) at %0t",
                 what, exp_v, got[0], got, $time);
    endfunction

    function void check_verdict(logic [7:0] got);
      logic exp_v;
      if (expected_verdicts.size() == 0) begin
        flag("with no path pending", 1'bx, got);
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (got[0] !== exp_v) flag("mismatch", exp_v, got);
      end
    endfunction

    function bit passed();
      return (errors == 0) && (expected_verdicts.size() == 0);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [7:0] path_byte
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;   // [0] verdict, [7:1] zero
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  verdict_scoreboard sb;
  logic [7:0]        path_q[$];
  bit                tx_gaps;
  bit                rx_gaps;
  bit                rx_hold_req;

  cip_path_electronic_key_check_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Handshake monitor: older verdicts are checked before a new byte is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_path_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Verdict receiver: random backpressure, or one long hold-off on request
  initial begin : receiver
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= !(rx_gaps && $urandom_range(0, 99) < 35);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, val);
  endtask

  // Identity write; junk in the unused upper bits when asked
  task automatic program_identity(logic [15:0] vendor, logic [15:0] device,
                                  logic [15:0] product, logic [6:0] major,
                                  logic [7:0] minor, bit junk);
    logic [31:0] up;
    up = junk ? $urandom : 32'd0;
    write_reg(REG_VENDOR, {up[31:16], vendor});
    write_reg(REG_DEVTYPE, {up[31:16], device});
    write_reg(REG_PRODCODE, {up[31:16], product});
    write_reg(REG_MAJOR_REV, {up[31:7], major});
    write_reg(REG_MINOR_REV, {up[31:8], minor});
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_path_byte(logic [7:0] b, logic lst);
    @(negedge clk_i);
    while (tx_gaps && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      s_axis_tlast  <= 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_path();
    foreach (path_q[i]) send_path_byte(path_q[i], i == path_q.size() - 1);
  endtask

  // Stop offering bytes and let every pending verdict come out
  task automatic wait_for_verdicts();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_verdicts.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Mostly the device's own value or a wildcard, sometimes off by one bit or random
  function automatic logic [15:0] pick_word(logic [15:0] own);
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1, 2, 3: return own;
      4: return own ^ (16'd1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void add_key();
    logic [15:0] w;
    logic [6:0]  major;
    logic [7:0]  minor;
    bit          compat;
    if ($urandom_range(0, 9) == 0) begin
      // special segment with a format other than the key format
      path_q.push_back(SEG_LOGICAL | LOG_TYPE_SPECIAL | 8'($urandom_range(1, 3)));
      return;
    end
    path_q.push_back(SEG_LOGICAL | LOG_TYPE_SPECIAL);
    path_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : KEY_FORMAT_FOUR);
    w = pick_word(sb.own_vendor);
    path_q.push_back(w[7:0]);
    path_q.push_back(w[15:8]);
    w = pick_word(sb.own_device);
    path_q.push_back(w[7:0]);
    path_q.push_back(w[15:8]);
    w = pick_word(sb.own_product);
    path_q.push_back(w[7:0]);
    path_q.push_back(w[15:8]);
    compat = 1'($urandom);
    case ($urandom_range(0, 3))
      0: major = compat ? sb.own_major : 7'd0;
      1, 2: major = sb.own_major;
      default: major = 7'($urandom);
    endcase
    if (compat)
      minor = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, sb.own_minor)) : 8'($urandom);
    else
      case ($urandom_range(0, 3))
        0: minor = 8'd0;
        1, 2: minor = sb.own_minor;
        default: minor = 8'($urandom);
      endcase
    path_q.push_back({compat, major});
    path_q.push_back(minor);
  endfunction

  // Class, instance, attribute and other plain logical members
  function automatic void add_logical();
    int unsigned t;
    logic [1:0]  fmt;
    logic [7:0]  head;
    int unsigned n;
    t = $urandom_range(0, 6);
    if (t >= 5) t++;   // type 5 is the special segment
    fmt = ($urandom_range(0, 11) == 0) ? FMT_RESERVED : 2'($urandom_range(0, 2));
    head = SEG_LOGICAL | {3'b000, 3'(t), fmt};
    case (fmt)
      FMT_8BIT: n = ((head & LOG_TYPE_MASK) == LOG_TYPE_EXTENDED) ? LEN_EXT_8BIT : LEN_8BIT;
      FMT_16BIT: n = LEN_16BIT;
      FMT_32BIT: n = LEN_32BIT;
      default: n = 1;
    endcase
    path_q.push_back(head);
    repeat (n - 1) path_q.push_back(8'($urandom));
  endfunction

  // Non-logical segment (often the zero pad) plus ignored trailing bytes
  function automatic void add_terminator();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) begin
      b = 8'h00;
    end else begin
      do b = 8'($urandom); while ((b & SEG_TYPE_MASK) == SEG_LOGICAL);
    end
    path_q.push_back(b);
    repeat ($urandom_range(0, 3)) path_q.push_back(8'($urandom));
  endfunction

  function automatic void build_path();
    int unsigned ending;
    int unsigned cut;
    path_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      // noise, biased toward logical headers
      repeat ($urandom_range(1, 12))
        path_q.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom) :
                         (SEG_LOGICAL | 8'($urandom_range(0, 31))));
    end else begin
      repeat ($urandom_range(0, 4))
        if ($urandom_range(0, 9) < 3) add_key();
        else add_logical();
      ending = $urandom_range(0, 9);
      if (ending >= 7 && path_q.size() > 1) begin
        cut = $urandom_range(1, path_q.size() - 1);
        while (path_q.size() > cut) void'(path_q.pop_back());
      end else if (ending >= 4 || path_q.size() == 0) begin
        add_terminator();
      end
    end
  endfunction

  initial begin : stimulus
    int unsigned sent;
    bit          paused;
    sb = new;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    rx_hold_req   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed paths
    program_identity(16'h1234, 16'h000C, 16'h0A5F, 7'd5, 8'd20, 1'b0);
    foreach (DIRECTED_BYTES[i]) send_path_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

    // random paths, one identity per phase
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      wait_for_verdicts();
      case (phase)
        0: program_identity(16'h0000, 16'h0000, 16'h0000, 7'h00, 8'h00, 1'b0);
        1: program_identity(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F, 8'hFF, 1'b1);
        default: program_identity(16'($urandom), 16'($urandom), 16'($urandom),
                                  7'($urandom), 8'($urandom), phase[0]);
      endcase
      tx_gaps = (phase != 2 && phase != 3);
      rx_gaps = (phase != 2);
      if (phase == 3) rx_hold_req = 1'b1;   // fill the block against a stalled output
      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_BYTES / PHASES) begin
        build_path();
        send_path();
        sent += path_q.size();
        if (phase == 4 && !paused && sent > 100) begin
          paused = 1'b1;
          wait_for_verdicts();
        end
      end
    end

    wait_for_verdicts();
    if (sb.passed())
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
